// ===== rtl/sfd_pkg.sv =====
// shared types and constants of the sensor frame deframer
package sfd_pkg;

	// register indexes of the configuration port
	localparam logic [7:0] REG_HEADER_FIRST    = 8'd0;
	localparam logic [7:0] REG_HEADER_SECOND   = 8'd1;
	localparam logic [7:0] REG_CHANNEL_COUNT   = 8'd2;
	localparam logic [7:0] REG_WATCHED_CHANNEL = 8'd3;

	// reset values of the registers
	localparam logic [7:0] HEADER_FIRST_RST    = 8'hAA;
	localparam logic [7:0] HEADER_SECOND_RST   = 8'h55;
	localparam logic [7:0] CHANNEL_COUNT_RST   = 8'd4;
	localparam logic [7:0] WATCHED_CHANNEL_RST = 8'd2;

	// parse phases
	localparam logic [1:0] PH_HUNT_FIRST  = 2'd0;
	localparam logic [1:0] PH_HUNT_SECOND = 2'd1;
	localparam logic [1:0] PH_BODY        = 2'd2;

	// body byte positions
	localparam logic [2:0] BODY_CHANNEL = 3'd0;
	localparam logic [2:0] BODY_STATUS  = 3'd1;
	localparam logic [2:0] BODY_TEMP0   = 3'd2;
	localparam logic [2:0] BODY_TEMP1   = 3'd3;
	localparam logic [2:0] BODY_TEMP2   = 3'd4;
	localparam logic [2:0] BODY_TEMP3   = 3'd5;
	localparam logic [2:0] BODY_LAST    = 3'd6;

	// outcome codes
	localparam logic [1:0] OUT_TEMP_STORED  = 2'd0;
	localparam logic [1:0] OUT_STATUS_ONLY  = 2'd1;
	localparam logic [1:0] OUT_SUM_MISMATCH = 2'd2;
	localparam logic [1:0] OUT_BAD_CHANNEL  = 2'd3;

	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [7:0] channel_count;
		logic [7:0] watched_channel;
	} cfg_t;

	typedef struct packed {
		logic        watched_update;
		logic [31:0] temperature_bits;
		logic [7:0]  sensor_status;
		logic [7:0]  channel;
		logic [1:0]  outcome;
	} res_t;

endpackage

// ===== rtl/sfd_cfg.sv =====
// configuration register file of the sensor frame deframer
module sfd_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [7:0]    wr_index,
	input  logic [7:0]    wr_data,
	output sfd_pkg::cfg_t cfg
);

	sfd_pkg::cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first    <= sfd_pkg::HEADER_FIRST_RST;
			cfg_q.header_second   <= sfd_pkg::HEADER_SECOND_RST;
			cfg_q.channel_count   <= sfd_pkg::CHANNEL_COUNT_RST;
			cfg_q.watched_channel <= sfd_pkg::WATCHED_CHANNEL_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				sfd_pkg::REG_HEADER_FIRST:    cfg_q.header_first    <= wr_data;
				sfd_pkg::REG_HEADER_SECOND:   cfg_q.header_second   <= wr_data;
				sfd_pkg::REG_CHANNEL_COUNT:   cfg_q.channel_count   <= wr_data;
				sfd_pkg::REG_WATCHED_CHANNEL: cfg_q.watched_channel <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/sfd_parse.sv =====
// header hunt, body collection and checksum check of the deframer
module sfd_parse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [7:0]    rx_byte,
	input  sfd_pkg::cfg_t cfg,
	output logic          last_byte,
	output logic          res_valid,
	output sfd_pkg::res_t res
);

	logic [1:0]  phase_q;
	logic [2:0]  count_q;
	logic [7:0]  sum_q;
	logic [7:0]  channel_q;
	logic [7:0]  status_q;
	logic [31:0] temp_q;

	logic        in_body;
	logic        chan_ok;

	assign in_body   = (phase_q == sfd_pkg::PH_BODY);
	assign last_byte = in_body && (count_q == sfd_pkg::BODY_LAST);
	assign chan_ok   = (channel_q != 8'd0) && (channel_q <= cfg.channel_count);

	// phase, byte count and running checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sfd_pkg::PH_HUNT_FIRST;
			count_q <= '0;
			sum_q   <= '0;
		end else if (fire) begin
			priority if (phase_q == sfd_pkg::PH_HUNT_SECOND) begin
				if (rx_byte == cfg.header_second) begin
					phase_q <= sfd_pkg::PH_BODY;
					count_q <= '0;
					sum_q   <= '0;
				end else if (rx_byte == cfg.header_first) begin
					phase_q <= sfd_pkg::PH_HUNT_SECOND;
				end else begin
					phase_q <= sfd_pkg::PH_HUNT_FIRST;
				end
			end else if (!in_body) begin
				phase_q <= (rx_byte == cfg.header_first) ? sfd_pkg::PH_HUNT_SECOND
				                                         : sfd_pkg::PH_HUNT_FIRST;
			end else if (!last_byte) begin
				sum_q   <= sum_q + rx_byte;
				count_q <= count_q + 3'd1;
			end else begin
				phase_q <= sfd_pkg::PH_HUNT_FIRST;
				count_q <= '0;
				sum_q   <= '0;
			end
		end
	end

	// body field holds
	always_ff @(posedge clk) begin
		if (fire && in_body) begin
			unique case (count_q)
				sfd_pkg::BODY_CHANNEL: channel_q      <= rx_byte;
				sfd_pkg::BODY_STATUS:  status_q       <= rx_byte;
				sfd_pkg::BODY_TEMP0:   temp_q[7:0]    <= rx_byte;
				sfd_pkg::BODY_TEMP1:   temp_q[15:8]   <= rx_byte;
				sfd_pkg::BODY_TEMP2:   temp_q[23:16]  <= rx_byte;
				sfd_pkg::BODY_TEMP3:   temp_q[31:24]  <= rx_byte;
				default: ;
			endcase
		end
	end

	// result of the checksum byte
	always_comb begin
		res.channel          = channel_q;
		res.sensor_status    = status_q;
		res.temperature_bits = temp_q;
		res.watched_update   = 1'b0;
		priority if (sum_q != rx_byte) begin
			res.outcome = sfd_pkg::OUT_SUM_MISMATCH;
		end else if (!chan_ok) begin
			res.outcome = sfd_pkg::OUT_BAD_CHANNEL;
		end else if (status_q != 8'd0) begin
			res.outcome = sfd_pkg::OUT_STATUS_ONLY;
		end else begin
			res.outcome        = sfd_pkg::OUT_TEMP_STORED;
			res.watched_update = (channel_q == cfg.watched_channel);
		end
	end

	assign res_valid = fire && last_byte;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sfd_pkg::BODY_LAST)
		else $error("body count past the checksum byte");
	a_back_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> (phase_q == sfd_pkg::PH_HUNT_FIRST) && (count_q == 3'd0))
		else $error("parser did not return to header hunt after a result");
	a_flag_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.watched_update |-> res.outcome == sfd_pkg::OUT_TEMP_STORED)
		else $error("update flag without a stored temperature");
	a_header_entry: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (phase_q == sfd_pkg::PH_HUNT_SECOND) && (rx_byte == cfg.header_second)
		|=> in_body && (count_q == 3'd0) && (sum_q == 8'd0))
		else $error("body did not start clean after the header");
`endif

endmodule

// ===== rtl/sfd_out.sv =====
// one-deep result register toward the output stream
module sfd_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  sfd_pkg::res_t res,
	input  logic          take,
	output logic          full,
	output sfd_pkg::res_t res_out
);

	logic          full_q;
	sfd_pkg::res_t res_q;

	// valid flag of the held result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (load) begin
			full_q <= 1'b1;
		end else if (take) begin
			full_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign full    = full_q;
	assign res_out = res_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !full_q || take)
		else $error("held result overwritten before it was taken");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		full_q && !take |=> full_q && $stable(res_q))
		else $error("stalled result changed");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		full_q && take && !load |=> !full_q)
		else $error("taken result still shown");
`endif

endmodule

// ===== rtl/sensor_frame_deframer.sv =====
// sensor frame deframer top level
//
// Byte stream in on s_tvalid/s_tready/s_tdata, one received byte per item.
// The parser hunts for the two header bytes, collects channel, status, four
// temperature bytes and a checksum byte, and on the checksum byte gives one
// result item on m_tvalid/m_tready/m_tdata/m_tuser: outcome code, raw fields
// and the watched-channel update flag. Other bytes give no result.
// Throughput is one byte per cycle: each byte passes the parse logic in the
// cycle it is accepted, and the result lands in a one-deep output register,
// so a result is shown in the cycle after its checksum byte is accepted.
// s_tready drops only when a result is held, the receiver stalls and the
// next byte is a checksum byte; header and body bytes keep flowing meanwhile,
// and the checksum byte waits until the held result drains.
// Configuration writes on cfg_valid/cfg_index/cfg_data are always taken and
// act at once; indexes 0 to 3 select header_first, header_second,
// channel_count and watched_channel, others are ignored.
// Reset clears the parser to header hunt, empties the output register and
// loads the register defaults 0xAA, 0x55, 4 and 2.
module sensor_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // channel, sensor_status, temperature_bits
	output logic [2:0]  m_tuser,   // outcome, watched_update
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	sfd_pkg::cfg_t cfg;
	sfd_pkg::res_t res;
	sfd_pkg::res_t res_out;
	logic          res_valid;
	logic          last_byte;
	logic          full;
	logic          fire;

	// handshakes, only a checksum byte needs a free output register
	assign cfg_ready = 1'b1;
	assign s_tready  = !full || m_tready || !last_byte;
	assign fire      = s_tvalid && s_tready;

	sfd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	sfd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.rx_byte   (s_tdata),
		.cfg       (cfg),
		.last_byte (last_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	sfd_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (res_valid),
		.res     (res),
		.take    (m_tready),
		.full    (full),
		.res_out (res_out)
	);

	// output packing
	assign m_tvalid = full;
	assign m_tdata  = {res_out.temperature_bits, res_out.sensor_status, res_out.channel};
	assign m_tuser  = {res_out.watched_update, res_out.outcome};

endmodule

// ===== tb/sv/tb_sensor_frame_deframer.sv =====
// self-checking testbench of the sensor frame deframer with a frame scoreboard
module tb_sensor_frame_deframer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REPORTS = 10;

	// scoreboard: tracks the parser, predicts frame results and checks them
	class frame_scoreboard;
		logic [7:0]    hdr_first;
		logic [7:0]    hdr_second;
		logic [7:0]    chan_count;
		logic [7:0]    watch_chan;
		logic [1:0]    phase;
		logic [2:0]    body_idx;
		logic [7:0]    sum;
		logic [7:0]    chan_q;
		logic [7:0]    stat_q;
		logic [31:0]   temp_q;
		sfd_pkg::res_t pending_frames[$];
		int            mismatches;

		function new();
			hdr_first  = sfd_pkg::HEADER_FIRST_RST;
			hdr_second = sfd_pkg::HEADER_SECOND_RST;
			chan_count = sfd_pkg::CHANNEL_COUNT_RST;
			watch_chan = sfd_pkg::WATCHED_CHANNEL_RST;
			phase      = sfd_pkg::PH_HUNT_FIRST;
			body_idx   = '0;
			sum        = '0;
			chan_q     = '0;
			stat_q     = '0;
			temp_q     = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [7:0] idx, logic [7:0] val);
			case (idx)
				sfd_pkg::REG_HEADER_FIRST: hdr_first = val;
				sfd_pkg::REG_HEADER_SECOND: hdr_second = val;
				sfd_pkg::REG_CHANNEL_COUNT: chan_count = val;
				sfd_pkg::REG_WATCHED_CHANNEL: watch_chan = val;
				default: ;
			endcase
		endfunction

		// advance the parser by one accepted byte, queue a result on the checksum byte
		function void note_rx_byte(logic [7:0] b);
			sfd_pkg::res_t r;
			int            sh;
			case (phase)
				sfd_pkg::PH_HUNT_SECOND: begin
					if (b == hdr_second) begin
						phase    = sfd_pkg::PH_BODY;
						body_idx = '0;
						sum      = '0;
					end else if (b == hdr_first) begin
						phase = sfd_pkg::PH_HUNT_SECOND;
					end else begin
						phase = sfd_pkg::PH_HUNT_FIRST;
					end
				end
				sfd_pkg::PH_BODY: begin
					if (body_idx != sfd_pkg::BODY_LAST) begin
						case (body_idx)
							sfd_pkg::BODY_CHANNEL: chan_q = b;
							sfd_pkg::BODY_STATUS: stat_q = b;
							default: begin
								sh = 8 * int'(body_idx - sfd_pkg::BODY_TEMP0);
								temp_q[sh +: 8] = b;
							end
						endcase
						sum      = sum + b;
						body_idx = body_idx + 3'd1;
					end else begin
						if (sum != b)
							r.outcome = sfd_pkg::OUT_SUM_MISMATCH;
						else if (chan_q >= 8'd1 && chan_q <= chan_count)
							r.outcome = (stat_q == 8'd0) ? sfd_pkg::OUT_TEMP_STORED
							                             : sfd_pkg::OUT_STATUS_ONLY;
						else
							r.outcome = sfd_pkg::OUT_BAD_CHANNEL;
						r.channel          = chan_q;
						r.sensor_status    = stat_q;
						r.temperature_bits = temp_q;
						r.watched_update   = (r.outcome == sfd_pkg::OUT_TEMP_STORED) &&
						                     (chan_q == watch_chan);
						pending_frames.push_back(r);
						phase    = sfd_pkg::PH_HUNT_FIRST;
						body_idx = '0;
						sum      = '0;
					end
				end
				// hunting the first header byte, unused phase acts the same
				default: phase = (b == hdr_first) ? sfd_pkg::PH_HUNT_SECOND
				                                  : sfd_pkg::PH_HUNT_FIRST;
			endcase
		endfunction

		// compare one result item with the oldest expected frame
		function void check_frame(sfd_pkg::res_t got);
			sfd_pkg::res_t want;
			if (pending_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected frame result: ",
						"outcome %0d ch %0d status %0d temp %h flag %0b",
						got.outcome, got.channel, got.sensor_status, got.temperature_bits,
						got.watched_update);
				return;
			end
			want = pending_frames.pop_front();
			if (got.outcome !== want.outcome || got.channel !== want.channel ||
					got.sensor_status !== want.sensor_status ||
					got.temperature_bits !== want.temperature_bits ||
					got.watched_update !== want.watched_update) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("frame mismatch: ",
						"expected outcome %0d ch %0d status %0d temp %h flag %0b, ",
						want.outcome, want.channel, want.sensor_status,
						want.temperature_bits, want.watched_update,
						"got outcome %0d ch %0d status %0d temp %h flag %0b",
						got.outcome, got.channel, got.sensor_status,
						got.temperature_bits, got.watched_update);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // rx_byte_value
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;    // channel, sensor_status, temperature_bits
	logic [2:0]  m_tuser;    // outcome, watched_update
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [7:0]  cfg_data;

	frame_scoreboard sb;
	bit  calm;          // no random idling on either side while set
	int  rx_hold_req;   // cycles the receiver is asked to hold off
	int  frame_bytes;

	sensor_frame_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("tb_sensor_frame_deframer NOT OK");
		$finish;
	end

	// receiver: random stalls, long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rx_hold_req != 0) begin
				hold_left   = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else begin
				m_tready = calm || ($urandom_range(99) >= 12);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		sfd_pkg::res_t got;
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			got.channel          = m_tdata[7:0];
			got.sensor_status    = m_tdata[15:8];
			got.temperature_bits = m_tdata[47:16];
			got.outcome          = m_tuser[1:0];
			got.watched_update   = m_tuser[2];
			sb.check_frame(got);
		end
	end

	// offer one byte, with random gaps before it
	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(99) < 12) begin
			s_tvalid = 1'b0;
			s_tdata  = 8'($urandom);
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_rx_byte(b);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// header, six body bytes and checksum, optionally corrupted
	task automatic send_frame(input logic [7:0] ch, input logic [7:0] st,
			input logic [31:0] temp, input bit bad_sum);
		logic [7:0] body [6];
		logic [7:0] sum;
		body = '{ch, st, temp[7:0], temp[15:8], temp[23:16], temp[31:24]};
		sum  = '0;
		foreach (body[i]) sum = sum + body[i];
		if (bad_sum)
			sum = sum + 8'($urandom_range(1, 255));
		send_byte(sb.hdr_first);
		send_byte(sb.hdr_second);
		foreach (body[i]) send_byte(body[i]);
		send_byte(sum);
		frame_bytes += 9;
	endtask

	// one random frame, maybe after noise, a bad or lone header or a cut-off frame
	task automatic random_frame();
		logic [7:0]  ch;
		logic [7:0]  st;
		logic [31:0] temp;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
		end else if (pick < 12) begin
			send_byte(sb.hdr_first);
			send_byte(8'($urandom));
		end else if (pick < 16) begin
			send_byte(sb.hdr_first);
			send_byte(sb.hdr_second);
			repeat ($urandom_range(0, 5)) send_byte(8'($urandom));
		end else if (pick < 21) begin
			send_byte(sb.hdr_first);
		end

		pick = $urandom_range(99);
		if (pick < 35)
			ch = sb.watch_chan;
		else if (pick < 70 && sb.chan_count != 8'd0)
			ch = 8'($urandom_range(1, sb.chan_count));
		else if (pick < 80)
			ch = 8'd0;
		else if (pick < 90 && sb.chan_count != 8'hFF)
			ch = 8'($urandom_range(int'(sb.chan_count) + 1, 255));
		else
			ch = 8'($urandom);
		st = ($urandom_range(3) == 0) ? 8'($urandom) : 8'd0;
		pick = $urandom_range(7);
		temp = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
		send_frame(ch, st, temp, $urandom_range(99) < 15);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// wait for every expected frame, then let the output register settle
	task automatic wait_drained();
		while (sb.pending_frames.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// one setting of the registers, then random frames worth nbytes
	task automatic run_phase(input logic [7:0] first, input logic [7:0] second,
			input logic [7:0] count, input logic [7:0] watched, input int nbytes,
			input bit quiet, input int hold);
		int stop_at;
		wait_drained();
		write_reg(sfd_pkg::REG_HEADER_FIRST, first);
		write_reg(sfd_pkg::REG_HEADER_SECOND, second);
		write_reg(sfd_pkg::REG_CHANNEL_COUNT, count);
		write_reg(sfd_pkg::REG_WATCHED_CHANNEL, watched);
		@(posedge clk);
		calm        = quiet;
		rx_hold_req = hold;
		@(negedge clk);
		stop_at = frame_bytes + nbytes;
		while (frame_bytes < stop_at) random_frame();
	endtask

	// stimulus
	initial begin : stimulus
		logic [7:0] cnt;
		sb          = new();
		calm        = 1'b0;
		rx_hold_req = 0;
		frame_bytes = 0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// repeated first header byte, watched channel update, extreme temperature
		send_byte(sb.hdr_first);
		send_frame(8'd2, 8'd0, 32'hFFFF_FFFF, 1'b0);
		// stray byte, then a broken header that restarts the hunt
		send_byte(8'h13);
		send_byte(sb.hdr_first);
		send_byte(8'h00);
		// checksum mismatch with extreme fields
		send_frame(8'hFF, 8'hFF, 32'h0, 1'b1);
		// status only, then channel zero out of range
		send_frame(8'd4, 8'h01, 32'h4120_0000, 1'b0);
		send_frame(8'd0, 8'd0, 32'h8000_0001, 1'b0);

		// defaults with a long receiver hold-off while bytes keep coming
		run_phase(8'hAA, 8'h55, 8'd4, 8'd2, 250, 1'b1, 300);
		// equal header bytes at both extremes
		run_phase(8'h00, 8'h00, 8'd1, 8'd1, 200, 1'b0, 0);
		run_phase(8'hFF, 8'hFF, 8'hFF, 8'hFF, 200, 1'b1, 0);
		// channel count zero: no channel valid
		run_phase(8'h3C, 8'hC3, 8'd0, 8'd0, 150, 1'b0, 0);
		run_phase(8'hFF, 8'h00, 8'd16, 8'd7, 200, 1'b0, 0);
		repeat (4) begin
			cnt = 8'($urandom_range(1, 255));
			run_phase(8'($urandom), 8'($urandom), cnt,
				($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1, cnt)),
				225, 1'b0, 0);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_frames.size() == 0)
			$display("tb_sensor_frame_deframer OK");
		else
			$display("tb_sensor_frame_deframer NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/sfd_pkg.sv
rtl/sfd_cfg.sv
rtl/sfd_parse.sv
rtl/sfd_out.sv
rtl/sensor_frame_deframer.sv
tb/sv/tb_sensor_frame_deframer.sv
